// ===== rtl/cbl_pkg.sv =====
// Shared types, constants and the cosine magnitude table builder
// for the cosine breathing level core. No dependencies.
`timescale 1ns / 1ps

package cbl_pkg;

    localparam int PHASE_BITS_DEFAULT = 10;

    localparam int ELAPSED_W = 16;
    localparam int PERIOD_W  = 20;
    localparam int ALPHA_W   = 8;
    localparam int LEVEL_W   = 8;
    localparam int MAG_W     = 8;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 20;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(10000);
    localparam logic [ALPHA_W-1:0]  ALPHA_RESET  = ALPHA_W'(255);

    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_MS  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_ALPHA = CFG_IDX_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_ADD,
        ST_WRAP,
        ST_DIV,
        ST_LOOKUP,
        ST_SCALE
    } state_t;

    localparam logic [63:0] Q30_ONE    = 64'd1 << 30;
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
    localparam int TAYLOR_TERMS = 5;
    localparam int COS_DIVS [TAYLOR_TERMS] = '{90, 56, 30, 12, 2};
    localparam int SIN_DIVS [TAYLOR_TERMS] = '{110, 72, 42, 20, 6};

    // Magnitude of cos (or sin) of the folded angle, Q2.30 Horner series,
    // scaled down to 0..128. Entry index is {use_sin, r}.
    function automatic logic [MAG_W-1:0] mag_entry(input int pb, input int idx);
        logic [63:0] r;
        logic [63:0] a;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] val;
        logic [63:0] mag;
        logic        use_sin;
        int          i;
        r       = 64'(idx & ((1 << (pb - 2)) - 1));
        use_sin = ((idx >> (pb - 2)) & 1) != 0;
        a       = (r * TWO_PI_Q30) >> pb;
        x2      = (a * a) >> 30;
        t       = Q30_ONE;
        if (use_sin) begin
            for (i = 0; i < TAYLOR_TERMS; i++) begin
                t = Q30_ONE - (((x2 * t) >> 30) / 64'(SIN_DIVS[i]));
            end
            val = (a * t) >> 30;
        end else begin
            for (i = 0; i < TAYLOR_TERMS; i++) begin
                t = Q30_ONE - (((x2 * t) >> 30) / 64'(COS_DIVS[i]));
            end
            val = t;
        end
        mag = val >> 23;
        if (mag > 64'd128) begin
            mag = 64'd128;
        end
        return mag[MAG_W-1:0];
    endfunction

endpackage

// ===== rtl/cosine_breathing_level_core.sv =====
// Cosine breathing level core: top level with sequencer, shared
// compare/subtract unit, restoring divider and cosine table ROM. Uses cbl_pkg.
`timescale 1ns / 1ps
// Each tick goes through the clamp, add and wrap steps, the bit-serial divider
// (PHASE_BITS + 20 steps on the shared compare/subtract unit), the ROM lookup and
// the scale step; the divider is skipped when period_ms is 0. A new tick is taken
// only once the last level is in the output register. Reset (aresetn low,
// synchronous): time in cycle 0, period_ms 10000, peak_alpha 255, sequencer idle,
// no result pending.

module cosine_breathing_level_core
    import cbl_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    // tick stream; tdata: [15:0] elapsed_ms
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [ELAPSED_W-1:0]   s_tdata,

    // level stream; tdata: [7:0] level
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [LEVEL_W-1:0]     m_tdata,

    // register writes: 0 period_ms, 1 peak_alpha
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // dividend is time << PHASE_BITS; one quotient bit per step
    localparam int DIV_W     = PERIOD_W + PHASE_BITS;
    localparam int CNT_W     = $clog2(DIV_W);
    localparam int R_W       = PHASE_BITS - 2;
    localparam int IDX_W     = PHASE_BITS - 1;
    localparam int TAB_DEPTH = 2 ** IDX_W;
    localparam int SUM_W     = PERIOD_W + 1;
    localparam int PROD_W    = ALPHA_W + MAG_W + 1;

    state_t state_reg, state_next;

    logic [PERIOD_W-1:0]  period_reg;
    logic [ALPHA_W-1:0]   alpha_reg;
    logic [PERIOD_W-1:0]  time_reg;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [PERIOD_W-1:0]  rem_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [MAG_W-1:0]     mag_reg;
    logic                 neg_reg;
    logic                 m_tvalid_reg;
    logic [LEVEL_W-1:0]   level_reg;

    // ------------------------------------------------------------------
    // Shared compare/subtract unit: a >= period and a - period.
    // Serves the elapsed clamp, the cycle wrap and every divider step.
    // ------------------------------------------------------------------
    logic [SUM_W-1:0] unit_a;
    logic [SUM_W:0]   unit_diff;
    logic             unit_ge;

    always_comb begin
        case (state_reg)
            ST_CLAMP: unit_a = SUM_W'(elapsed_reg);
            ST_WRAP:  unit_a = sum_reg;
            ST_DIV:   unit_a = {rem_reg, quo_reg[DIV_W-1]};
            default:  unit_a = '0;
        endcase
        unit_diff = {1'b0, unit_a} - {2'b00, period_reg};
        unit_ge   = ~unit_diff[SUM_W];
    end

    // wrapped time, taken in the wrap step
    logic [PERIOD_W-1:0] time_wrapped;
    assign time_wrapped = unit_ge ? unit_diff[PERIOD_W-1:0] : sum_reg[PERIOD_W-1:0];

    // ------------------------------------------------------------------
    // Phase folding: quadrant in the top two bits, mirror the remainder
    // past the eighth turn so the table only covers 0..pi/4.
    // ------------------------------------------------------------------
    logic [PHASE_BITS-1:0] phase;
    logic [1:0]            quad;
    logic [R_W-1:0]        r_raw;
    logic [R_W:0]          r_mirror;
    logic                  do_mirror;
    logic                  use_sin;
    logic [IDX_W-1:0]      rom_idx;
    logic                  cos_neg;

    always_comb begin
        phase     = quo_reg[PHASE_BITS-1:0];
        quad      = phase[PHASE_BITS-1 -: 2];
        r_raw     = phase[R_W-1:0];
        do_mirror = r_raw[R_W-1] && (r_raw[R_W-2:0] != '0);
        r_mirror  = {1'b1, {R_W{1'b0}}} - {1'b0, r_raw};
        use_sin   = quad[0] ^ do_mirror;
        rom_idx   = {use_sin, (do_mirror ? r_mirror[R_W-1:0] : r_raw)};
        cos_neg   = quad[1] ^ quad[0];
    end

    // cosine/sine magnitude ROM, built at elaboration
    logic [MAG_W-1:0] mag_rom [TAB_DEPTH];

    for (genvar g = 0; g < TAB_DEPTH; g++) begin : g_rom
        assign mag_rom[g] = mag_entry(PHASE_BITS, g);
    end

    // registered ROM read; result is used in the scale step
    always_ff @(posedge aclk) begin
        mag_reg <= mag_rom[rom_idx];
        neg_reg <= cos_neg;
    end

    // ------------------------------------------------------------------
    // Scale: peak_alpha * (128 -/+ mag) / 256
    // ------------------------------------------------------------------
    logic [MAG_W:0]    shifted;
    logic [PROD_W-1:0] prod;
    logic              out_free;

    always_comb begin
        shifted  = neg_reg ? (9'd128 + {1'b0, mag_reg}) : (9'd128 - {1'b0, mag_reg});
        prod     = PROD_W'(alpha_reg) * PROD_W'(shifted);
        out_free = !m_tvalid_reg || m_tready;
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP: state_next = ST_ADD;
            ST_ADD:   state_next = ST_WRAP;
            ST_WRAP: begin
                // zero period: phase is zero, skip the divider
                state_next = (period_reg == '0) ? ST_LOOKUP : ST_DIV;
            end
            ST_DIV: begin
                if (cnt_reg == CNT_W'(DIV_W - 1)) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: state_next = ST_SCALE;
            ST_SCALE: begin
                // hold until the output register is free
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                elapsed_reg <= s_tdata;
            end
            ST_CLAMP: begin
                // elapsed >= period means period fits the elapsed width
                if (unit_ge) begin
                    elapsed_reg <= period_reg[ELAPSED_W-1:0];
                end
            end
            ST_ADD: begin
                sum_reg <= SUM_W'(time_reg) + SUM_W'(elapsed_reg);
            end
            ST_WRAP: begin
                rem_reg <= '0;
                cnt_reg <= '0;
                if (period_reg == '0) begin
                    quo_reg <= '0;
                end else begin
                    quo_reg <= {time_wrapped, {PHASE_BITS{1'b0}}};
                end
            end
            ST_DIV: begin
                // shift in one quotient bit, keep the partial remainder
                quo_reg <= {quo_reg[DIV_W-2:0], unit_ge};
                rem_reg <= unit_ge ? unit_diff[PERIOD_W-1:0] : unit_a[PERIOD_W-1:0];
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            default: begin
            end
        endcase
    end

    // time in cycle: the only state carried from tick to tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg <= '0;
        end else if (state_reg == ST_WRAP) begin
            time_reg <= time_wrapped;
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers; writes are always taken
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= PERIOD_RESET;
            alpha_reg  <= ALPHA_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_PERIOD_MS:  period_reg <= cfg_data[PERIOD_W-1:0];
                REG_PEAK_ALPHA: alpha_reg  <= cfg_data[ALPHA_W-1:0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_SCALE && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_SCALE && out_free) begin
            level_reg <= prod[15:8];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = level_reg;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for cosine_breathing_level_core: drives ticks and
// register writes, predicts each breathing level and checks the level stream.
// Depends on rtl/cbl_pkg.sv and rtl/cosine_breathing_level_core.sv.
`timescale 1ns / 1ps

module tb_top;
    import cbl_pkg::*;

    localparam int PB = PHASE_BITS_DEFAULT;
    // Settling wait after the last level, before a register write.
    localparam int DRAIN_CYCLES = 2 * (PB + 26);
    localparam int HOLD_CYCLES  = 600;
    localparam int ITEMS_PER_SETTING = 70;

    localparam logic [63:0] UNIT_Q30   = 64'd1 << 30;
    localparam logic [63:0] TWO_PI_FIX = 64'd6746518852;
    localparam int COSINE_DIV [5] = '{90, 56, 30, 12, 2};
    localparam int SINE_DIV   [5] = '{110, 72, 42, 20, 6};

    // Indexes past the register map; writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_FIRST = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LAST  = CFG_IDX_W'(255);

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [ELAPSED_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [LEVEL_W-1:0]    m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Predictor copy of the block's registers and running time.
    logic [PERIOD_W-1:0] pred_period = PERIOD_RESET;
    logic [ALPHA_W-1:0]  pred_alpha  = ALPHA_RESET;
    logic [PERIOD_W-1:0] pred_time   = '0;

    logic [ELAPSED_W-1:0] tick_q [$];
    logic [LEVEL_W-1:0]   level_q [$];
    logic [LEVEL_W-1:0]   expected_level;
    int ticks_queued = 0;
    int ticks_taken = 0;
    int mismatch_count = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_left = 0;
    bit hold_arm = 1'b0;
    bit hold_spent = 1'b0;

    cosine_breathing_level_core #(
        .PHASE_BITS(PB)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    task automatic log_mismatch(input string msg);
        if (mismatch_count < 50) begin
            $display("tb: mismatch at %0t: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    // Horner form of the cosine or sine Taylor series in Q2.30.
    function automatic logic [63:0] taylor_q30(input logic [63:0] x2, input bit sine);
        logic [63:0] t;
        int d;
        t = UNIT_Q30;
        for (int i = 0; i < 5; i++) begin
            d = sine ? SINE_DIV[i] : COSINE_DIV[i];
            t = UNIT_Q30 - (((x2 * t) >> 30) / 64'(d));
        end
        return t;
    endfunction

    // -cos(2*pi*ph / 2^PB) truncated toward zero, plus 128: 0..256.
    function automatic logic [8:0] raised_neg_cos(input logic [PB-1:0] ph);
        logic [63:0] quarter;
        logic [63:0] r;
        logic [63:0] a;
        logic [63:0] x2;
        logic [63:0] val;
        logic [63:0] mag;
        logic [1:0]  quad;
        bit          sine;
        quarter = 64'd1 << (PB - 2);
        quad    = ph[PB-1:PB-2];
        r       = 64'(ph[PB-3:0]);
        sine    = quad[0];
        // Fold the angle into 0..pi/4 and swap sine for cosine.
        if (2 * r > quarter) begin
            r    = quarter - r;
            sine = !sine;
        end
        a   = (r * TWO_PI_FIX) >> PB;
        x2  = (a * a) >> 30;
        val = sine ? ((a * taylor_q30(x2, 1'b1)) >> 30) : taylor_q30(x2, 1'b0);
        mag = val >> 23;
        if (mag > 64'd128) begin
            mag = 64'd128;
        end
        return (quad == 2'd1 || quad == 2'd2) ? 9'(128 + mag) : 9'(128 - mag);
    endfunction

    // Advance the running time by one tick and return the level it yields.
    function automatic logic [LEVEL_W-1:0] advance_breathing(input logic [ELAPSED_W-1:0] elapsed);
        logic [31:0]   e;
        logic [31:0]   sum;
        logic [63:0]   quot;
        logic [PB-1:0] ph;
        logic [31:0]   lvl;
        e = 32'(elapsed);
        if (e > 32'(pred_period)) begin
            e = 32'(pred_period);
        end
        sum = 32'(pred_time) + e;
        // Subtract once only, even when a lowered period leaves time far above it.
        if (sum >= 32'(pred_period)) begin
            sum = sum - 32'(pred_period);
        end
        pred_time = sum[PERIOD_W-1:0];
        ph = '0;
        if (pred_period != '0) begin
            quot = (64'(pred_time) << PB) / 64'(pred_period);
            ph   = quot[PB-1:0];
        end
        lvl = (32'(pred_alpha) * 32'(raised_neg_cos(ph))) / 32'd256;
        return lvl[LEVEL_W-1:0];
    endfunction

    // Tick driver: hold a transfer until taken, then offer the next or idle.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                level_q.push_back(advance_breathing(s_tdata));
                ticks_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (tick_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= tick_q.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here so the block backs up into its input.
    always @(posedge aclk) begin
        if (hold_arm && !hold_spent) begin
            hold_left  <= HOLD_CYCLES;
            hold_spent <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Level monitor: compare every transfer with the oldest prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (level_q.size() == 0) begin
                    log_mismatch($sformatf("level %0d with none expected", m_tdata));
                end else begin
                    expected_level = level_q.pop_front();
                    if (m_tdata !== expected_level) begin
                        log_mismatch($sformatf("level %0d, expected %0d",
                                               m_tdata, expected_level));
                    end
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic queue_tick(input logic [ELAPSED_W-1:0] v);
        tick_q.push_back(v);
        ticks_queued++;
    endtask

    // Wait until every tick is taken and every level has come, then let it settle.
    task automatic wait_drained();
        while (ticks_taken != ticks_queued || level_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        wait_drained();
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_PERIOD_MS) begin
            pred_period = val[PERIOD_W-1:0];
        end else if (idx == REG_PEAK_ALPHA) begin
            pred_alpha = val[ALPHA_W-1:0];
        end
    endtask

    function automatic logic [ELAPSED_W-1:0] random_elapsed();
        logic [ELAPSED_W-1:0] v;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: v = ELAPSED_W'($urandom_range(0, 2047));
            5, 6, 7:       v = ELAPSED_W'($urandom());
            8:             v = $urandom_range(1) ? '1 : '0;
            default: begin
                // Land on the clamp edge of the current period.
                v = ELAPSED_W'(pred_period) + ELAPSED_W'($urandom_range(2)) - 1'b1;
            end
        endcase
        return v;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_period();
        case ($urandom_range(9))
            0:          return CFG_DATA_W'(1000);
            1:          return '1;
            2, 3, 4, 5: return CFG_DATA_W'($urandom_range(1000, 20000));
            6, 7, 8:    return CFG_DATA_W'($urandom_range(1000, 1048575));
            default:    return CFG_DATA_W'($urandom_range(0, 999));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_alpha();
        case ($urandom_range(5))
            0:       return CFG_DATA_W'(0);
            1:       return CFG_DATA_W'(255);
            default: return CFG_DATA_W'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        tx_idle_pct = 28;
        rx_idle_pct = 72;

        // Reset settings: extremes and clamp edges of the elapsed time.
        queue_tick(16'd0);
        queue_tick(16'hFFFF);
        queue_tick(16'd1);
        queue_tick(16'd9999);
        queue_tick(16'd10000);
        queue_tick(16'd10001);
        queue_tick(16'h5555);
        queue_tick(16'hAAAA);
        queue_tick(16'd2500);
        queue_tick(16'd2500);

        // Longest period: build up a large running time.
        write_register(REG_PERIOD_MS, '1);
        for (int i = 0; i < 6; i++) begin
            queue_tick(16'hFFFF);
        end

        // Shortest usual period leaves the time far above it: subtract once only.
        write_register(REG_PERIOD_MS, CFG_DATA_W'(1000));
        write_register(REG_PEAK_ALPHA, CFG_DATA_W'(128));
        queue_tick(16'hFFFF);
        queue_tick(16'd0);
        queue_tick(16'd999);
        queue_tick(16'd1);

        // Writes outside the register map must change nothing.
        write_register(REG_UNMAPPED_FIRST, CFG_DATA_W'($urandom()));
        write_register(REG_UNMAPPED_LAST, '1);
        queue_tick(16'd700);

        // Zero period: time frozen, level zero.
        write_register(REG_PERIOD_MS, '0);
        queue_tick(16'hFFFF);
        queue_tick(16'd0);

        write_register(REG_PERIOD_MS, CFG_DATA_W'(1000));
        write_register(REG_PEAK_ALPHA, CFG_DATA_W'(0));
        queue_tick(16'd500);

        // Random part: receiver-heavy idling, then sender-heavy, then none.
        for (int mode = 0; mode < 3; mode++) begin
            wait_drained();
            tx_idle_pct = (mode == 0) ? 28 : (mode == 1) ? 72 : 0;
            rx_idle_pct = (mode == 0) ? 72 : (mode == 1) ? 28 : 0;
            for (int k = 0; k < 5; k++) begin
                if ($urandom_range(1)) begin
                    write_register(REG_PEAK_ALPHA, random_alpha());
                    write_register(REG_PERIOD_MS, random_period());
                end else begin
                    write_register(REG_PERIOD_MS, random_period());
                    write_register(REG_PEAK_ALPHA, random_alpha());
                end
                if (mode == 2 && k == 0) begin
                    hold_arm <= 1'b1;
                end
                for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
                    queue_tick(random_elapsed());
                end
            end
        end

        wait_drained();
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
